/* hw/rtl/tcprx_pkg.sv */
`timescale 1ns / 1ps

package tcprx_pkg;

    typedef enum logic [3:0] {
        ST_CLOSED     = 4'd0,
        ST_LISTEN     = 4'd1,
        ST_SYN_SENT   = 4'd2,
        ST_SYN_RCVD   = 4'd3,
        ST_ESTAB      = 4'd4,
        ST_FIN_WAIT1  = 4'd5,
        ST_FIN_WAIT2  = 4'd6,
        ST_CLOSING    = 4'd7,
        ST_TIME_WAIT  = 4'd8,
        ST_CLOSE_WAIT = 4'd9,
        ST_LAST_ACK   = 4'd10
    } t_conn_state;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_ESTABLISHED = 3'd1,
        EV_ACCEPT_Q    = 3'd2,
        EV_TIME_WAIT   = 3'd3,
        EV_TORN_DOWN   = 3'd4
    } t_conn_event;

    typedef enum logic [1:0] {
        WS_OK     = 2'd0,
        WS_CLOSED = 2'd1,
        WS_RESET  = 2'd2
    } t_wake_status;

    localparam logic MODE_SEGMENT = 1'b0;
    localparam logic MODE_COMMAND = 1'b1;

    // one parsed segment or local command
    typedef struct packed {
        logic        mode;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_fin;
        logic        flag_rst;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] payload_len;
        logic [31:0] send_next;
        logic [3:0]  load_state;
        logic [31:0] init_send_seq;
    } t_rx_item;

    // per-connection context
    typedef struct packed {
        t_conn_state st;
        logic [31:0] snd_ini;
        logic [31:0] snd_una;
        logic [31:0] rcv_ini;
        logic [31:0] rcv_nxt;
        logic [31:0] rcv_wnd;
    } t_rx_ctx;

    typedef struct packed {
        t_conn_state  conn_state;
        logic         send_reset;
        logic         send_ack;
        logic         send_syn_ack;
        logic         kick_transmit;
        logic [30:0]  acked_bytes;
        logic         deliver_data;
        logic         wake_send;
        logic         wake_recv;
        logic         wake_conn;
        t_wake_status wake_status;
        t_conn_event  conn_event;
    } t_rx_result;

    // serial arithmetic: a - b as a signed 32-bit difference
    function automatic logic f_diff_pos(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic f_diff_neg(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

/* hw/rtl/tcp_connection_receive_fsm.sv */
`timescale 1ns / 1ps
// pipeline: an input register and then a result register lie between the input transaction and
// the result transaction, and the result can be held back by a stall on the output
// throughput: one item per cycle unless the output stalls; the connection context is read and
// rewritten between the registers as items advance, so each item sees what its predecessor left
// reset: synchronous active-low; context returns to closed with all sequence pointers zero,
// both pipeline registers empty, ready for input as soon as reset is released

module tcp_connection_receive_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic        i_flag_syn,
    input  logic        i_flag_ack,
    input  logic        i_flag_fin,
    input  logic        i_flag_rst,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_payload_len,
    input  logic [31:0] i_send_next,
    input  logic [3:0]  i_load_state,
    input  logic [31:0] i_init_send_seq,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_conn_state,
    output logic        o_send_reset,
    output logic        o_send_ack,
    output logic        o_send_syn_ack,
    output logic        o_kick_transmit,
    output logic [30:0] o_acked_bytes,
    output logic        o_deliver_data,
    output logic        o_wake_send,
    output logic        o_wake_recv,
    output logic        o_wake_conn,
    output logic [1:0]  o_wake_status,
    output logic [2:0]  o_conn_event
);

    tcprx_pkg::t_rx_item   r_in;
    logic                  r_in_valid;
    tcprx_pkg::t_rx_ctx    r_ctx;
    tcprx_pkg::t_rx_ctx    n_ctx;
    tcprx_pkg::t_rx_result r_out;
    tcprx_pkg::t_rx_result n_out;
    logic                  r_out_valid;
    logic                  w_advance;

    // item moves from input register to result register
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    tcprx_step u_step (
        .i_item (r_in),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx       <= '{st: tcprx_pkg::ST_CLOSED, default: '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.mode          <= i_mode;
            r_in.flag_syn      <= i_flag_syn;
            r_in.flag_ack      <= i_flag_ack;
            r_in.flag_fin      <= i_flag_fin;
            r_in.flag_rst      <= i_flag_rst;
            r_in.seq_number    <= i_seq_number;
            r_in.ack_number    <= i_ack_number;
            r_in.payload_len   <= i_payload_len;
            r_in.send_next     <= i_send_next;
            r_in.load_state    <= i_load_state;
            r_in.init_send_seq <= i_init_send_seq;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_conn_state    = r_out.conn_state;
    assign o_send_reset    = r_out.send_reset;
    assign o_send_ack      = r_out.send_ack;
    assign o_send_syn_ack  = r_out.send_syn_ack;
    assign o_kick_transmit = r_out.kick_transmit;
    assign o_acked_bytes   = r_out.acked_bytes;
    assign o_deliver_data  = r_out.deliver_data;
    assign o_wake_send     = r_out.wake_send;
    assign o_wake_recv     = r_out.wake_recv;
    assign o_wake_conn     = r_out.wake_conn;
    assign o_wake_status   = r_out.wake_status;
    assign o_conn_event    = r_out.conn_event;

    a_teardown_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_conn_event == tcprx_pkg::EV_TORN_DOWN)
        |-> o_conn_state == tcprx_pkg::ST_CLOSED)
        else $error("teardown event without closed state");

    a_status_needs_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wake_status != tcprx_pkg::WS_OK)
        |-> (o_wake_send && o_wake_recv && o_wake_conn))
        else $error("non-ok wake status without full wake");

    a_acked_wakes_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_acked_bytes != 31'd0) |-> o_wake_send)
        else $error("acknowledged bytes without send wake");

    a_ctx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_advance)) |-> $stable(r_ctx))
        else $error("connection context changed without a transaction");

endmodule

/* hw/rtl/tcprx_step.sv */
`timescale 1ns / 1ps

module tcprx_step (
    input  tcprx_pkg::t_rx_item   i_item,
    input  tcprx_pkg::t_rx_ctx    i_ctx,
    output tcprx_pkg::t_rx_ctx    o_ctx,
    output tcprx_pkg::t_rx_result o_res
);

    logic [31:0] w_ack_diff;
    logic        w_ack_ok;
    logic        w_hs_fail;
    logic        w_ack_adv;
    logic        w_take;
    logic [31:0] w_nxt;
    logic        w_data_wake;
    logic        c_do_ack;
    logic        c_do_data;
    logic        c_kick_en;

    assign w_ack_diff = i_item.ack_number - i_ctx.snd_una;
    assign w_ack_ok   = !tcprx_pkg::f_diff_neg(i_item.ack_number, i_ctx.snd_una)
                     && !tcprx_pkg::f_diff_pos(i_item.ack_number, i_item.send_next);
    assign w_hs_fail  = i_item.flag_ack
                     && (!tcprx_pkg::f_diff_pos(i_item.ack_number, i_ctx.snd_ini)
                         || tcprx_pkg::f_diff_pos(i_item.ack_number, i_item.send_next));
    assign w_ack_adv  = tcprx_pkg::f_diff_pos(i_item.ack_number, i_ctx.snd_una);

    // receive pointer after in-order payload and fin
    assign w_take      = (i_item.payload_len != 16'd0) && (i_item.seq_number == i_ctx.rcv_nxt);
    assign w_nxt       = i_ctx.rcv_nxt
                       + (w_take ? {16'd0, i_item.payload_len} : 32'd0)
                       + {31'd0, i_item.flag_fin};
    assign w_data_wake = i_item.flag_fin || tcprx_pkg::f_diff_pos(w_nxt, i_ctx.rcv_wnd);

    always_comb begin
        o_ctx     = i_ctx;
        o_res     = '0;
        c_do_ack  = 1'b0;
        c_do_data = 1'b0;
        c_kick_en = 1'b0;

        if (i_item.mode == tcprx_pkg::MODE_COMMAND) begin
            o_ctx.st      = (i_item.load_state > 4'(tcprx_pkg::ST_LAST_ACK))
                          ? tcprx_pkg::ST_CLOSED
                          : tcprx_pkg::t_conn_state'(i_item.load_state);
            o_ctx.snd_ini = i_item.init_send_seq;
            o_ctx.snd_una = i_item.init_send_seq;
        end else if (i_ctx.st == tcprx_pkg::ST_CLOSED) begin
            o_res.send_reset = !i_item.flag_rst;
        end else if (i_item.flag_rst && i_item.flag_ack) begin
            o_ctx.st          = tcprx_pkg::ST_CLOSED;
            o_res.wake_send   = 1'b1;
            o_res.wake_recv   = 1'b1;
            o_res.wake_conn   = 1'b1;
            o_res.wake_status = tcprx_pkg::WS_RESET;
            o_res.conn_event  = tcprx_pkg::EV_TORN_DOWN;
        end else begin
            unique case (i_ctx.st)
                tcprx_pkg::ST_LISTEN: begin
                    if (i_item.flag_syn) begin
                        o_ctx.rcv_ini      = i_item.seq_number;
                        o_ctx.rcv_nxt      = i_item.seq_number + 32'd1;
                        o_ctx.rcv_wnd      = i_item.seq_number + 32'd1;
                        o_res.send_syn_ack = 1'b1;
                        o_ctx.st           = tcprx_pkg::ST_SYN_SENT;
                    end
                end
                tcprx_pkg::ST_SYN_SENT, tcprx_pkg::ST_SYN_RCVD: begin
                    if (w_hs_fail) begin
                        o_res.send_reset = 1'b1;
                    end else begin
                        // one bump for our syn being acknowledged
                        if (i_item.flag_ack
                            && (i_ctx.st == tcprx_pkg::ST_SYN_SENT || i_item.flag_syn)) begin
                            o_ctx.snd_una = i_ctx.snd_una + 32'd1;
                        end
                        if (i_item.flag_syn) begin
                            o_ctx.rcv_ini = i_item.seq_number;
                            o_ctx.rcv_nxt = i_item.seq_number + 32'd1;
                            o_ctx.rcv_wnd = i_item.seq_number + 32'd1;
                            if (i_item.flag_ack) begin
                                o_res.send_ack   = 1'b1;
                                o_ctx.st         = tcprx_pkg::ST_ESTAB;
                                o_res.wake_conn  = 1'b1;
                                o_res.conn_event = tcprx_pkg::EV_ESTABLISHED;
                            end else begin
                                o_ctx.st           = tcprx_pkg::ST_SYN_RCVD;
                                o_res.send_syn_ack = 1'b1;
                            end
                        end else if (i_item.flag_ack && i_ctx.st == tcprx_pkg::ST_SYN_SENT) begin
                            o_ctx.st         = tcprx_pkg::ST_ESTAB;
                            o_res.wake_conn  = 1'b1;
                            o_res.conn_event = tcprx_pkg::EV_ACCEPT_Q;
                        end
                    end
                end
                default: begin
                    if (i_item.flag_syn) begin
                        o_res.send_reset = 1'b1;
                    end else begin
                        unique case (i_ctx.st)
                            tcprx_pkg::ST_ESTAB, tcprx_pkg::ST_CLOSE_WAIT: begin
                                c_do_ack  = i_item.flag_ack;
                                c_do_data = 1'b1;
                                c_kick_en = 1'b1;
                                if (i_item.flag_fin) begin
                                    o_ctx.st = tcprx_pkg::ST_CLOSE_WAIT;
                                end
                            end
                            tcprx_pkg::ST_FIN_WAIT1: begin
                                c_do_ack  = i_item.flag_ack;
                                c_do_data = 1'b1;
                                if (i_item.flag_fin) begin
                                    if (w_ack_adv) begin
                                        o_ctx.st         = tcprx_pkg::ST_TIME_WAIT;
                                        o_res.conn_event = tcprx_pkg::EV_TIME_WAIT;
                                    end else begin
                                        o_ctx.st  = tcprx_pkg::ST_CLOSING;
                                        c_kick_en = 1'b1;
                                    end
                                end else begin
                                    o_ctx.st = tcprx_pkg::ST_FIN_WAIT2;
                                end
                            end
                            tcprx_pkg::ST_FIN_WAIT2: begin
                                c_do_ack  = i_item.flag_ack;
                                c_do_data = 1'b1;
                                if (i_item.flag_fin) begin
                                    o_ctx.st         = tcprx_pkg::ST_TIME_WAIT;
                                    o_res.conn_event = tcprx_pkg::EV_TIME_WAIT;
                                end
                            end
                            tcprx_pkg::ST_CLOSING: begin
                                c_do_ack = i_item.flag_ack;
                                if (w_ack_adv) begin
                                    o_ctx.st         = tcprx_pkg::ST_TIME_WAIT;
                                    o_res.conn_event = tcprx_pkg::EV_TIME_WAIT;
                                end else begin
                                    c_kick_en = 1'b1;
                                end
                            end
                            tcprx_pkg::ST_TIME_WAIT: begin
                                c_do_ack         = i_item.flag_ack;
                                o_res.send_ack   = i_item.flag_fin;
                                o_res.conn_event = tcprx_pkg::EV_TIME_WAIT;
                            end
                            default: begin
                                // last-ack: final ack closes
                                if (i_item.flag_ack) begin
                                    o_ctx.st          = tcprx_pkg::ST_CLOSED;
                                    o_res.wake_send   = 1'b1;
                                    o_res.wake_recv   = 1'b1;
                                    o_res.wake_conn   = 1'b1;
                                    o_res.wake_status = tcprx_pkg::WS_CLOSED;
                                    o_res.conn_event  = tcprx_pkg::EV_TORN_DOWN;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        if (c_do_ack && w_ack_ok) begin
            o_res.acked_bytes   = w_ack_diff[30:0];
            o_res.wake_send     = 1'b1;
            o_ctx.snd_una       = i_item.ack_number;
            o_res.kick_transmit = c_kick_en;
        end

        if (c_do_data) begin
            o_res.deliver_data = w_take;
            o_ctx.rcv_nxt      = w_nxt;
            if (w_data_wake) begin
                o_res.wake_recv = 1'b1;
                if (i_item.flag_fin) begin
                    o_res.wake_conn   = 1'b1;
                    o_res.wake_send   = 1'b1;
                    o_res.wake_status = tcprx_pkg::WS_CLOSED;
                    o_res.send_ack    = 1'b1;
                end
            end
        end

        o_res.conn_state = o_ctx.st;
    end

endmodule
